FILE: hdl/dtcs_pkg.sv
// ----------------------------------------------------------------------------
// dtcs_pkg
// Types, codes and tables shared by the transfer controller sequencer.
// ----------------------------------------------------------------------------
package dtcs_pkg;

    localparam int NUM_SOURCES_DEF = 17;
    localparam int TABLE_SIZE      = 17;
    localparam int BUNDLE_MAX      = 4;
    localparam int BUNDLE_IDX_W    = $clog2(BUNDLE_MAX);
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [5:0]  STALL_BASE = 6'd26;
    localparam logic [15:0] REG_MODE   = 16'd0;
    localparam logic [15:0] REG_SRC    = 16'd2;
    localparam logic [15:0] REG_DST    = 16'd4;
    localparam logic [15:0] REG_CNT    = 16'd6;

    typedef enum logic [1:0] {
        MODE_REQ     = 2'd0,
        MODE_SERVICE = 2'd1,
        MODE_REPLY   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        K_ACCEPT = 4'd0,
        K_REJECT = 4'd1,
        K_RD16   = 4'd2,
        K_RD8    = 4'd3,
        K_WR16   = 4'd4,
        K_WR8    = 4'd5,
        K_STALL  = 4'd6,
        K_CLEAR  = 4'd7,
        K_ACK    = 4'd8,
        K_RAISE  = 4'd9,
        K_BREAK  = 4'd10,
        K_DONE   = 4'd11
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_PTR  = 4'd1,
        PH_MODE = 4'd2,
        PH_SRC  = 4'd3,
        PH_DST  = 4'd4,
        PH_CNT  = 4'd5,
        PH_DRD  = 4'd6,
        PH_DWR  = 4'd7,
        PH_WBS  = 4'd8,
        PH_WBD  = 4'd9,
        PH_WBC  = 4'd10
    } phase_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] address;
        logic [15:0] data;
        logic [4:0]  source;
        logic [7:0]  vector;
        logic [5:0]  stall;
    } result_t;

    // results caused by one request, res[0] goes out first
    typedef struct packed {
        result_t [BUNDLE_MAX-1:0] res;
        logic [BUNDLE_IDX_W:0]    count;
    } bundle_t;

    function automatic logic [7:0] table_addr(input logic [4:0] s);
        logic [7:0] a;
        case (s)
            5'd0:    a = 8'hC0;
            5'd1:    a = 8'hC8;
            5'd2:    a = 8'hCA;
            5'd3:    a = 8'hCC;
            5'd4:    a = 8'hD0;
            5'd5:    a = 8'hD2;
            5'd6:    a = 8'hD4;
            5'd7:    a = 8'hD8;
            5'd8:    a = 8'hDA;
            5'd9:    a = 8'hDC;
            5'd10:   a = 8'hE0;
            5'd11:   a = 8'hE2;
            5'd12:   a = 8'hEA;
            5'd13:   a = 8'hEC;
            5'd14:   a = 8'hF2;
            5'd15:   a = 8'hF4;
            5'd16:   a = 8'hF8;
            default: a = 8'h00;
        endcase
        return a;
    endfunction

    function automatic logic [2:0] region_wait_states(input logic [1:0] cls, input logic word);
        logic [2:0] st;
        case (cls)
            2'd0:    st = 3'd2;
            2'd1:    st = 3'd3;
            2'd2:    st = word ? 3'd4 : 3'd2;
            default: st = word ? 3'd6 : 3'd3;
        endcase
        return st;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [15:0] a,
                                            input logic [15:0] d, input logic [4:0] s,
                                            input logic [7:0] v, input logic [5:0] st);
        result_t r;
        r.kind    = k;
        r.address = a;
        r.data    = d;
        r.source  = s;
        r.vector  = v;
        r.stall   = st;
        return r;
    endfunction

endpackage

FILE: hdl/data_transfer_controller_sequencer.sv
// ----------------------------------------------------------------------------
// data_transfer_controller_sequencer
// Interrupt-triggered transfer controller acting as a bus master.
// ----------------------------------------------------------------------------
// Takes one request per cycle on the s_ side whenever the internal queue
// has room: transfer requests, a start-service request, or a bus reply to
// the last access issued. Each request yields zero to four results on the
// m_ side, one per cycle, the last marked with m_tlast; results run at one
// per cycle while m_tready is high. The sequencer updates its state in the
// cycle the request is taken; a two-entry queue of result bundles decouples
// it from the result stage, so the input stalls only when both entries are
// waiting. No clearing pass after reset. maximum_mode must be written on the
// cfg channel only while the block is idle; the block itself does not
// enforce this. The cfg channel is always ready.
module data_transfer_controller_sequencer #(
    parameter int NUM_SOURCES = dtcs_pkg::NUM_SOURCES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: maximum_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // source[4:0], vector[12:5], read_data[28:13], region[30:29]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // address[15:0], data[31:16], source_out[36:32],
                                  // vector_out[44:37], stall_cycles[50:45]
    output logic [3:0]  m_tuser,  // kind[3:0]
    output logic        m_tlast
);

    logic              in_fire;
    logic              push;
    dtcs_pkg::bundle_t push_bundle;
    dtcs_pkg::bundle_t head;
    logic              full;
    logic              empty;
    logic              pop;
    dtcs_pkg::result_t out_res;

    // config is always taken at once
    assign cfg_ready = 1'b1;

    // front takes a request whenever the queue can hold its results
    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    dtcs_front #(
        .NUM_SOURCES(NUM_SOURCES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .in_mode     (s_tuser),
        .in_source   (s_tdata[4:0]),
        .in_vector   (s_tdata[12:5]),
        .in_read_data(s_tdata[28:13]),
        .in_region   (s_tdata[30:29]),
        .push        (push),
        .push_bundle (push_bundle)
    );

    dtcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_bundle(push_bundle),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    dtcs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_res  (out_res),
        .out_last (m_tlast)
    );

    // result packing
    assign m_tuser = out_res.kind;
    assign m_tdata = {5'd0, out_res.stall, out_res.vector, out_res.source,
                      out_res.data, out_res.address};

    // a drain-finished result always closes its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dtcs_pkg::K_DONE |-> m_tlast)
        else $error("done result not marked last");

    // a rejection is the only result of its request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dtcs_pkg::K_REJECT |-> m_tlast)
        else $error("reject result not marked last");

    // never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full && in_fire)
        else $error("bundle pushed without an accepted request");

endmodule

FILE: hdl/dtcs_front.sv
// ----------------------------------------------------------------------------
// dtcs_front
// Request classification and transfer sequencer; emits one result bundle per request that yields results.
// ----------------------------------------------------------------------------
module dtcs_front #(
    parameter int NUM_SOURCES = dtcs_pkg::NUM_SOURCES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_data,
    input  logic             in_fire,
    input  logic [1:0]       in_mode,
    input  logic [4:0]       in_source,
    input  logic [7:0]       in_vector,
    input  logic [15:0]      in_read_data,
    input  logic [1:0]       in_region,
    output logic             push,
    output dtcs_pkg::bundle_t push_bundle
);

    localparam int SRC_W = $clog2(NUM_SOURCES);

    dtcs_pkg::phase_t phase_reg, phase_next;
    logic [NUM_SOURCES-1:0] pend_reg, pend_next;
    logic [7:0]  vec_store [NUM_SOURCES];
    logic        vec_we;
    logic        tbl_dbl_reg;
    logic [4:0]  cur_reg, cur_next;
    logic [15:0] tab_reg, tab_next;
    logic [2:0]  mb_reg, mb_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] dp_reg, dp_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] moved_reg, moved_next;
    logic [5:0]  tot_reg, tot_next;

    logic [SRC_W-1:0] first;
    logic        req_ok;
    logic        word;
    logic [15:0] step;
    logic [15:0] va;
    logic [7:0]  tbl;
    logic [2:0]  acc;

    always_comb begin
        first = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (pend_reg[i]) first = SRC_W'(i);
        end
    end

    assign req_ok = (32'(in_source) < NUM_SOURCES) && (dtcs_pkg::table_addr(in_source) != 8'd0);
    assign word   = mb_reg[2];
    assign step   = word ? 16'd2 : 16'd1;
    assign tbl    = dtcs_pkg::table_addr(5'(first));
    assign va     = tbl_dbl_reg ? ({7'd0, tbl, 1'b0} + 16'd2) : {8'd0, tbl};
    assign acc    = dtcs_pkg::region_wait_states(in_region, word);

    always_comb begin
        logic [dtcs_pkg::BUNDLE_IDX_W:0] n;
        logic do_start;
        logic [5:0] t;
        n = '0;
        do_start = 1'b0;
        t = '0;
        push_bundle = '0;
        phase_next = phase_reg;
        pend_next = pend_reg;
        vec_we = 1'b0;
        cur_next = cur_reg;
        tab_next = tab_reg;
        mb_next = mb_reg;
        sp_next = sp_reg;
        dp_next = dp_reg;
        cnt_next = cnt_reg;
        moved_next = moved_reg;
        tot_next = tot_reg;
        if (in_fire) begin
            unique case (dtcs_pkg::mode_t'(in_mode))
                dtcs_pkg::MODE_REQ: begin
                    if (!req_ok) begin
                        push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] = dtcs_pkg::make_result(
                            dtcs_pkg::K_REJECT, '0, '0, in_source, '0, '0);
                        n = n + 1'b1;
                    end else begin
                        pend_next[in_source[SRC_W-1:0]] = 1'b1;
                        vec_we = 1'b1;
                        push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] = dtcs_pkg::make_result(
                            dtcs_pkg::K_ACCEPT, '0, '0, in_source, '0, '0);
                        n = n + 1'b1;
                        push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] = dtcs_pkg::make_result(
                            dtcs_pkg::K_BREAK, '0, '0, in_source, '0, '0);
                        n = n + 1'b1;
                    end
                end
                dtcs_pkg::MODE_SERVICE: begin
                    if (phase_reg == dtcs_pkg::PH_IDLE) do_start = 1'b1;
                end
                dtcs_pkg::MODE_REPLY: begin
                    unique case (phase_reg)
                        dtcs_pkg::PH_PTR: begin
                            tab_next = in_read_data;
                            push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_RD16,
                                in_read_data + dtcs_pkg::REG_MODE, '0, cur_reg, '0, '0);
                            n = n + 1'b1;
                            phase_next = dtcs_pkg::PH_MODE;
                        end
                        dtcs_pkg::PH_MODE: begin
                            mb_next = in_read_data[15:13];
                            push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_RD16,
                                tab_reg + dtcs_pkg::REG_SRC, '0, cur_reg, '0, '0);
                            n = n + 1'b1;
                            phase_next = dtcs_pkg::PH_SRC;
                        end
                        dtcs_pkg::PH_SRC: begin
                            sp_next = in_read_data;
                            push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_RD16,
                                tab_reg + dtcs_pkg::REG_DST, '0, cur_reg, '0, '0);
                            n = n + 1'b1;
                            phase_next = dtcs_pkg::PH_DST;
                        end
                        dtcs_pkg::PH_DST: begin
                            dp_next = in_read_data;
                            push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_RD16,
                                tab_reg + dtcs_pkg::REG_CNT, '0, cur_reg, '0, '0);
                            n = n + 1'b1;
                            phase_next = dtcs_pkg::PH_CNT;
                        end
                        dtcs_pkg::PH_CNT: begin
                            cnt_next = in_read_data;
                            push_bundle.res[0] = dtcs_pkg::make_result(
                                word ? dtcs_pkg::K_RD16 : dtcs_pkg::K_RD8,
                                sp_reg, '0, cur_reg, '0, '0);
                            n = n + 1'b1;
                            phase_next = dtcs_pkg::PH_DRD;
                        end
                        dtcs_pkg::PH_DRD: begin
                            moved_next = word ? in_read_data : {8'd0, in_read_data[7:0]};
                            tot_next = dtcs_pkg::STALL_BASE + {3'd0, acc};
                            push_bundle.res[0] = dtcs_pkg::make_result(
                                word ? dtcs_pkg::K_WR16 : dtcs_pkg::K_WR8,
                                dp_reg, moved_next, cur_reg, '0, '0);
                            n = n + 1'b1;
                            phase_next = dtcs_pkg::PH_DWR;
                        end
                        dtcs_pkg::PH_DWR: begin
                            t = tot_reg + {3'd0, acc} + (mb_reg[1] ? 6'd2 : 6'd0)
                                + (mb_reg[0] ? 6'd2 : 6'd0);
                            tot_next = t;
                            if (mb_reg[1]) sp_next = sp_reg + step;
                            if (mb_reg[0]) dp_next = dp_reg + step;
                            cnt_next = cnt_reg - 16'd1;
                            if (mb_reg[1]) begin
                                push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_WR16,
                                    tab_reg + dtcs_pkg::REG_SRC, sp_next, cur_reg, '0, '0);
                                phase_next = dtcs_pkg::PH_WBS;
                            end else if (mb_reg[0]) begin
                                push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_WR16,
                                    tab_reg + dtcs_pkg::REG_DST, dp_next, cur_reg, '0, '0);
                                phase_next = dtcs_pkg::PH_WBD;
                            end else begin
                                push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_WR16,
                                    tab_reg + dtcs_pkg::REG_CNT, cnt_next, cur_reg, '0, '0);
                                phase_next = dtcs_pkg::PH_WBC;
                            end
                            n = n + 1'b1;
                        end
                        dtcs_pkg::PH_WBS: begin
                            if (mb_reg[0]) begin
                                push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_WR16,
                                    tab_reg + dtcs_pkg::REG_DST, dp_reg, cur_reg, '0, '0);
                                phase_next = dtcs_pkg::PH_WBD;
                            end else begin
                                push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_WR16,
                                    tab_reg + dtcs_pkg::REG_CNT, cnt_reg, cur_reg, '0, '0);
                                phase_next = dtcs_pkg::PH_WBC;
                            end
                            n = n + 1'b1;
                        end
                        dtcs_pkg::PH_WBD: begin
                            push_bundle.res[0] = dtcs_pkg::make_result(dtcs_pkg::K_WR16,
                                tab_reg + dtcs_pkg::REG_CNT, cnt_reg, cur_reg, '0, '0);
                            n = n + 1'b1;
                            phase_next = dtcs_pkg::PH_WBC;
                        end
                        dtcs_pkg::PH_WBC: begin
                            push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] =
                                dtcs_pkg::make_result(dtcs_pkg::K_STALL, '0, '0, cur_reg,
                                                      '0, tot_reg);
                            n = n + 1'b1;
                            if (cur_reg >= 5'd1 && cur_reg <= 5'd3) begin
                                push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] =
                                    dtcs_pkg::make_result(dtcs_pkg::K_ACK, '0, '0, cur_reg,
                                        vec_store[cur_reg[SRC_W-1:0]], '0);
                            end else begin
                                push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] =
                                    dtcs_pkg::make_result(dtcs_pkg::K_CLEAR, '0, moved_reg,
                                                          cur_reg, '0, '0);
                            end
                            n = n + 1'b1;
                            if (cnt_reg == 16'd0) begin
                                push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] =
                                    dtcs_pkg::make_result(dtcs_pkg::K_RAISE, '0, '0, cur_reg,
                                                          '0, '0);
                                n = n + 1'b1;
                            end
                            do_start = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            // pick the lowest pending source, or report the drain finished
            if (do_start) begin
                if (pend_reg == '0) begin
                    phase_next = dtcs_pkg::PH_IDLE;
                    push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] = dtcs_pkg::make_result(
                        dtcs_pkg::K_DONE, '0, '0, '0, '0, '0);
                end else begin
                    pend_next[first] = 1'b0;
                    cur_next = 5'(first);
                    phase_next = dtcs_pkg::PH_PTR;
                    push_bundle.res[n[dtcs_pkg::BUNDLE_IDX_W-1:0]] = dtcs_pkg::make_result(
                        dtcs_pkg::K_RD16, va, '0, 5'(first), '0, '0);
                end
                n = n + 1'b1;
            end
        end
        push_bundle.count = n;
        push = in_fire && (n != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= dtcs_pkg::PH_IDLE;
            pend_reg     <= '0;
            tbl_dbl_reg  <= 1'b0;
            cur_reg      <= '0;
            tab_reg      <= '0;
            mb_reg       <= '0;
            sp_reg       <= '0;
            dp_reg       <= '0;
            cnt_reg      <= '0;
            moved_reg    <= '0;
            tot_reg      <= '0;
        end else begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            if (cfg_valid) tbl_dbl_reg <= cfg_data;
            cur_reg   <= cur_next;
            tab_reg   <= tab_next;
            mb_reg    <= mb_next;
            sp_reg    <= sp_next;
            dp_reg    <= dp_next;
            cnt_reg   <= cnt_next;
            moved_reg <= moved_next;
            tot_reg   <= tot_next;
        end
    end

    // vector store, written only by accepted requests
    always_ff @(posedge aclk) begin
        if (vec_we) vec_store[in_source[SRC_W-1:0]] <= in_vector;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_mode == dtcs_pkg::MODE_REQ && req_ok
        |=> pend_reg[$past(in_source[SRC_W-1:0])])
        else $error("accepted request did not leave its pending bit set");

endmodule

FILE: hdl/dtcs_queue.sv
// ----------------------------------------------------------------------------
// dtcs_queue
// Short queue of result bundles between sequencer and result stage.
// ----------------------------------------------------------------------------
module dtcs_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dtcs_pkg::bundle_t push_bundle,
    input  logic              pop,
    output dtcs_pkg::bundle_t head,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = $clog2(dtcs_pkg::QUEUE_DEPTH);

    dtcs_pkg::bundle_t store [dtcs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (PTR_W+1)'(dtcs_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = store[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) store[wr_reg] <= push_bundle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

endmodule

FILE: hdl/dtcs_back.sv
// ----------------------------------------------------------------------------
// dtcs_back
// Result stage: plays out each bundle one result per cycle, while out_ready allows, into an output register.
// ----------------------------------------------------------------------------
module dtcs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  dtcs_pkg::bundle_t head,
    input  logic              empty,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output dtcs_pkg::result_t out_res,
    output logic              out_last
);

    logic [dtcs_pkg::BUNDLE_IDX_W-1:0] idx_reg;
    logic                              valid_reg;
    dtcs_pkg::result_t                 res_reg;
    logic                              last_reg;
    logic                              load;
    logic                              is_last;

    assign load    = !valid_reg || out_ready;
    assign is_last = ({1'b0, idx_reg} + 1'b1) == head.count;
    assign pop     = load && !empty && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= !empty;
            if (!empty) idx_reg <= is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            res_reg  <= head.res[idx_reg];
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

FILE: bench/tb_data_transfer_controller_sequencer.sv
// ----------------------------------------------------------------------------
// tb_data_transfer_controller_sequencer
// Self-checking bench for the transfer controller sequencer.
// ----------------------------------------------------------------------------
// Drives requests, service starts and bus replies on the s_ side and checks
// every result on the m_ side against a local model of the sequencer, kept
// in step at each accepted request. Both sides idle at random; the mode
// register is rewritten between drains, minimum and maximum mode included.
module tb_data_transfer_controller_sequencer;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        dtcs_pkg::kind_t kind;
        logic [15:0] address;
        logic [15:0] data;
        logic [4:0]  source;
        logic [7:0]  vector;
        logic [5:0]  stall;
        logic        last;
    } expect_res_t;

    // vector table addresses in source order
    localparam logic [7:0] VEC_ADDR [0:16] = '{
        8'hC0, 8'hC8, 8'hCA, 8'hCC, 8'hD0, 8'hD2, 8'hD4, 8'hD8, 8'hDA,
        8'hDC, 8'hE0, 8'hE2, 8'hEA, 8'hEC, 8'hF2, 8'hF4, 8'hF8
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // model state
    logic        tbl_dbl;
    logic [16:0] pend;
    logic [7:0]  vec_mem [0:16];
    dtcs_pkg::phase_t ph;
    logic [4:0]  cur_src;
    logic [15:0] reg_base;
    logic [2:0]  mbits;
    logic [15:0] src_ptr, dst_ptr, xfer_cnt, moved;
    logic [5:0]  stall_sum;

    expect_res_t expected_q [$];
    int          n_items;
    int          n_errors;
    int          idle_cycles;
    int          m_hold;
    bit          quiet;

    always #4 aclk = ~aclk;

    data_transfer_controller_sequencer uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // ------------------------------------------------------------------
    // model of the sequencer
    // ------------------------------------------------------------------
    function automatic logic [5:0] bus_states(logic [1:0] cls, logic word);
        case (cls)
            2'd0:    return 6'd2;
            2'd1:    return 6'd3;
            2'd2:    return word ? 6'd4 : 6'd2;
            default: return word ? 6'd6 : 6'd3;
        endcase
    endfunction

    task automatic push_res(dtcs_pkg::kind_t k, logic [15:0] a, logic [15:0] d,
                            logic [4:0] s, logic [7:0] v, logic [5:0] st, inout int n);
        expect_res_t r;
        r = '{k, a, d, s, v, st, 1'b0};
        expected_q.push_back(r);
        n++;
    endtask

    task automatic start_source(inout int n);
        int s;
        logic [15:0] va;
        if (pend == '0) begin
            ph = dtcs_pkg::PH_IDLE;
            push_res(dtcs_pkg::K_DONE, '0, '0, '0, '0, '0, n);
        end else begin
            s = 0;
            while (!pend[s]) s++;
            pend[s] = 1'b0;
            cur_src = s[4:0];
            va = {8'h00, VEC_ADDR[s]};
            if (tbl_dbl) va = va * 16'd2 + 16'd2;
            ph = dtcs_pkg::PH_PTR;
            push_res(dtcs_pkg::K_RD16, va, '0, cur_src, '0, '0, n);
        end
    endtask

    task automatic write_back_next(dtcs_pkg::phase_t from, inout int n);
        // write back the words that changed, count always last
        if (from == dtcs_pkg::PH_DWR && mbits[1]) begin
            ph = dtcs_pkg::PH_WBS;
            push_res(dtcs_pkg::K_WR16, reg_base + dtcs_pkg::REG_SRC, src_ptr, cur_src,
                     '0, '0, n);
        end else if (from != dtcs_pkg::PH_WBD && mbits[0]) begin
            ph = dtcs_pkg::PH_WBD;
            push_res(dtcs_pkg::K_WR16, reg_base + dtcs_pkg::REG_DST, dst_ptr, cur_src,
                     '0, '0, n);
        end else begin
            ph = dtcs_pkg::PH_WBC;
            push_res(dtcs_pkg::K_WR16, reg_base + dtcs_pkg::REG_CNT, xfer_cnt, cur_src,
                     '0, '0, n);
        end
    endtask

    task automatic bus_reply(logic [15:0] rd, logic [1:0] cls, inout int n);
        logic word;
        logic [15:0] step;
        word = mbits[2];
        step = word ? 16'd2 : 16'd1;
        case (ph)
            dtcs_pkg::PH_PTR: begin
                reg_base = rd; ph = dtcs_pkg::PH_MODE;
                push_res(dtcs_pkg::K_RD16, reg_base + dtcs_pkg::REG_MODE, '0, cur_src,
                         '0, '0, n);
            end
            dtcs_pkg::PH_MODE: begin
                mbits = rd[15:13]; ph = dtcs_pkg::PH_SRC;
                push_res(dtcs_pkg::K_RD16, reg_base + dtcs_pkg::REG_SRC, '0, cur_src,
                         '0, '0, n);
            end
            dtcs_pkg::PH_SRC: begin
                src_ptr = rd; ph = dtcs_pkg::PH_DST;
                push_res(dtcs_pkg::K_RD16, reg_base + dtcs_pkg::REG_DST, '0, cur_src,
                         '0, '0, n);
            end
            dtcs_pkg::PH_DST: begin
                dst_ptr = rd; ph = dtcs_pkg::PH_CNT;
                push_res(dtcs_pkg::K_RD16, reg_base + dtcs_pkg::REG_CNT, '0, cur_src,
                         '0, '0, n);
            end
            dtcs_pkg::PH_CNT: begin
                xfer_cnt = rd; ph = dtcs_pkg::PH_DRD;
                push_res(word ? dtcs_pkg::K_RD16 : dtcs_pkg::K_RD8, src_ptr, '0, cur_src,
                         '0, '0, n);
            end
            dtcs_pkg::PH_DRD: begin
                moved = word ? rd : {8'h00, rd[7:0]};
                stall_sum = dtcs_pkg::STALL_BASE + bus_states(cls, word);
                ph = dtcs_pkg::PH_DWR;
                push_res(word ? dtcs_pkg::K_WR16 : dtcs_pkg::K_WR8, dst_ptr, moved, cur_src,
                         '0, '0, n);
            end
            dtcs_pkg::PH_DWR: begin
                stall_sum = stall_sum + bus_states(cls, word);
                if (mbits[1]) begin
                    src_ptr = src_ptr + step; stall_sum = stall_sum + 6'd2;
                end
                if (mbits[0]) begin
                    dst_ptr = dst_ptr + step; stall_sum = stall_sum + 6'd2;
                end
                xfer_cnt = xfer_cnt - 16'd1;
                write_back_next(dtcs_pkg::PH_DWR, n);
            end
            dtcs_pkg::PH_WBS, dtcs_pkg::PH_WBD: write_back_next(ph, n);
            dtcs_pkg::PH_WBC: begin
                push_res(dtcs_pkg::K_STALL, '0, '0, cur_src, '0, stall_sum, n);
                if (cur_src >= 5'd1 && cur_src <= 5'd3)
                    push_res(dtcs_pkg::K_ACK, '0, '0, cur_src, vec_mem[cur_src], '0, n);
                else
                    push_res(dtcs_pkg::K_CLEAR, '0, moved, cur_src, '0, '0, n);
                if (xfer_cnt == '0) push_res(dtcs_pkg::K_RAISE, '0, '0, cur_src, '0, '0, n);
                start_source(n);
            end
            default: ;
        endcase
    endtask

    task automatic model_request(dtcs_pkg::mode_t m, logic [4:0] src, logic [7:0] vec,
                                 logic [15:0] rd, logic [1:0] cls);
        int n;
        n = 0;
        case (m)
            dtcs_pkg::MODE_REQ: begin
                if (src > 5'd16) begin
                    push_res(dtcs_pkg::K_REJECT, '0, '0, src, '0, '0, n);
                end else begin
                    pend[src] = 1'b1;
                    vec_mem[src] = vec;
                    push_res(dtcs_pkg::K_ACCEPT, '0, '0, src, '0, '0, n);
                    push_res(dtcs_pkg::K_BREAK, '0, '0, src, '0, '0, n);
                end
            end
            dtcs_pkg::MODE_SERVICE: if (ph == dtcs_pkg::PH_IDLE) start_source(n);
            dtcs_pkg::MODE_REPLY:   bus_reply(rd, cls, n);
            default: ;
        endcase
        if (n > 0) expected_q[expected_q.size()-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(dtcs_pkg::mode_t m, logic [4:0] src, logic [7:0] vec,
                                logic [15:0] rd, logic [1:0] cls);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {1'b0, cls, rd, vec, src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_request(m, src, vec, rd, cls);
        n_items++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_mode_reg(logic v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tbl_dbl = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // answer each bus access until the drain ends, with stray items if noisy; mode_sel < 0 means random
    task automatic run_drain(int mode_sel, bit noisy);
        logic [15:0] rd;
        while (ph != dtcs_pkg::PH_IDLE) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_request(dtcs_pkg::MODE_SERVICE, 5'($urandom), 8'($urandom),
                                    16'($urandom), 2'($urandom));
                    1: send_request(dtcs_pkg::MODE_NONE, 5'($urandom), 8'($urandom),
                                    16'($urandom), 2'($urandom));
                    default: send_request(dtcs_pkg::MODE_REQ, 5'($urandom), 8'($urandom),
                                          16'($urandom), 2'($urandom));
                endcase
            end else begin
                rd = 16'($urandom);
                if (ph == dtcs_pkg::PH_MODE && mode_sel >= 0) rd[15:13] = mode_sel[2:0];
                if (ph == dtcs_pkg::PH_CNT && $urandom_range(0, 3) == 0)
                    rd = 16'($urandom_range(0, 1));
                send_request(dtcs_pkg::MODE_REPLY, 5'($urandom), 8'($urandom), rd,
                             2'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_requests_and_word_moves();
        write_mode_reg(1'b0);
        send_request(dtcs_pkg::MODE_REQ, 5'd0, 8'h00, 16'h0000, 2'd0);
        send_request(dtcs_pkg::MODE_REQ, 5'd1, 8'hFF, 16'hFFFF, 2'd3);
        send_request(dtcs_pkg::MODE_REQ, 5'd16, 8'hA5, 16'h0000, 2'd0);
        send_request(dtcs_pkg::MODE_REQ, 5'd17, 8'h5A, 16'h0000, 2'd0);
        send_request(dtcs_pkg::MODE_REQ, 5'd31, 8'hFF, 16'h0000, 2'd0);
        send_request(dtcs_pkg::MODE_SERVICE, 5'd0, 8'h00, 16'h0000, 2'd0);
        run_drain(7, 1'b0);
        // ignored items and an empty service
        send_request(dtcs_pkg::MODE_REPLY, 5'd0, 8'h00, 16'hFFFF, 2'd3);
        send_request(dtcs_pkg::MODE_NONE, 5'd31, 8'hFF, 16'hFFFF, 2'd3);
        send_request(dtcs_pkg::MODE_SERVICE, 5'd0, 8'h00, 16'h0000, 2'd0);
    endtask

    task automatic test_doubled_table_byte_moves();
        write_mode_reg(1'b1);
        send_request(dtcs_pkg::MODE_REQ, 5'd3, 8'h81, 16'h0000, 2'd0);
        send_request(dtcs_pkg::MODE_REQ, 5'd12, 8'h7E, 16'h0000, 2'd0);
        send_request(dtcs_pkg::MODE_SERVICE, 5'd0, 8'h00, 16'h0000, 2'd0);
        run_drain(0, 1'b0);
        send_request(dtcs_pkg::MODE_REQ, 5'd2, 8'h3C, 16'h0000, 2'd0);
        send_request(dtcs_pkg::MODE_SERVICE, 5'd0, 8'h00, 16'h0000, 2'd0);
        run_drain(3, 1'b0);
    endtask

    task automatic test_random_drains();
        int k;
        logic [4:0] src;
        while (n_items < 360) begin
            if ($urandom_range(0, 4) == 0) write_mode_reg(1'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                // broken round: no requests, a stray reply and a service
                send_request(dtcs_pkg::MODE_REPLY, 5'($urandom), 8'($urandom),
                             16'($urandom), 2'($urandom));
                send_request(dtcs_pkg::MODE_SERVICE, 5'($urandom), 8'($urandom),
                             16'($urandom), 2'($urandom));
                continue;
            end
            k = $urandom_range(1, 4);
            repeat (k) begin
                src = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
                send_request(dtcs_pkg::MODE_REQ, src, 8'($urandom), 16'($urandom),
                             2'($urandom));
            end
            send_request(dtcs_pkg::MODE_SERVICE, 5'($urandom), 8'($urandom),
                         16'($urandom), 2'($urandom));
            run_drain(-1, 1'b1);
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (m_hold > 0) begin
            m_hold   <= m_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                   : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        expect_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result kind %0d", m_tuser);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_tuser != e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_tuser); n_errors++;
                end
                if (m_tdata[15:0] != e.address) begin
                    $error("address: expected %h, got %h", e.address, m_tdata[15:0]);
                    n_errors++;
                end
                if (m_tdata[31:16] != e.data) begin
                    $error("data: expected %h, got %h", e.data, m_tdata[31:16]); n_errors++;
                end
                if (m_tdata[36:32] != e.source) begin
                    $error("source_out: expected %0d, got %0d", e.source, m_tdata[36:32]);
                    n_errors++;
                end
                if (m_tdata[44:37] != e.vector) begin
                    $error("vector_out: expected %h, got %h", e.vector, m_tdata[44:37]);
                    n_errors++;
                end
                if (m_tdata[50:45] != e.stall) begin
                    $error("stall_cycles: expected %0d, got %0d", e.stall, m_tdata[50:45]);
                    n_errors++;
                end
                if (m_tlast != e.last) begin
                    $error("last: expected %0b, got %0b", e.last, m_tlast); n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_data_transfer_controller_sequencer: done, errors");
            $finish;
        end
    end

    initial begin
        tbl_dbl = 1'b0; pend = '0; ph = dtcs_pkg::PH_IDLE; cur_src = '0; reg_base = '0;
        mbits = '0; src_ptr = '0; dst_ptr = '0; xfer_cnt = '0; moved = '0;
        stall_sum = '0; n_items = 0;
        quiet = 1'b0;
        foreach (vec_mem[i]) vec_mem[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_requests_and_word_moves();
        test_doubled_table_byte_moves();
        test_random_drains();
        write_mode_reg(1'b0);
        wait_idle();
        if (n_errors == 0)
            $display("tb_data_transfer_controller_sequencer: done, clean");
        else
            $display("tb_data_transfer_controller_sequencer: done, errors");
        $finish;
    end

endmodule
